### rtl/ddpu_pkg.sv
// Shared types, constants and tables of the differential drive pose update unit.
package ddpu_pkg;

   // Default number of CORDIC rotations
   localparam int CORDIC_STEPS_DEF = 24;

   // Register reset values (unsigned Q8.8)
   localparam logic [15:0] RADIUS_RESET = 16'd128;
   localparam logic [15:0] TRACK_RESET  = 16'd5120;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_TRACK  = 2'd1;

   // Arithmetic constants
   localparam logic signed [33:0] GAIN_Q30       = 34'sh026DD3B6A;
   localparam logic [31:0]        HALF_DEG_ANGLE = 32'd5965232;
   localparam logic [31:0]        RAD_TO_ANGLE   = 32'd683565276;

   // Divider dividend width (heading step numerator after dropping 8 bits)
   localparam int DIV_BITS = 56;

   // Item modes
   typedef enum logic [2:0] {
      MODE_STEP         = 3'd0,
      MODE_TURN_LEFT    = 3'd1,
      MODE_TURN_RIGHT   = 3'd2,
      MODE_ZERO_HEADING = 3'd3,
      MODE_SET_POS      = 3'd4
   } mode_type;

   // CORDIC handshake
   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic              busy;
      logic signed [33:0] cos_val;
      logic signed [33:0] sin_val;
   } cordic_rsp_type;

   // Divider handshake
   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [15:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] quotient;
   } div_rsp_type;

   // Arctangent of 2^-i as a binary angle (2^32 = full turn)
   function automatic logic signed [33:0] atan_at(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0:  v = 34'sh020000000;
         5'd1:  v = 34'sh012E4051E;
         5'd2:  v = 34'sh009FB385B;
         5'd3:  v = 34'sh0051111D4;
         5'd4:  v = 34'sh0028B0D43;
         5'd5:  v = 34'sh00145D7E1;
         5'd6:  v = 34'sh000A2F61E;
         5'd7:  v = 34'sh000517C55;
         5'd8:  v = 34'sh00028BE53;
         5'd9:  v = 34'sh000145F2F;
         5'd10: v = 34'sh0000A2F98;
         5'd11: v = 34'sh0000517CC;
         5'd12: v = 34'sh000028BE6;
         5'd13: v = 34'sh0000145F3;
         5'd14: v = 34'sh00000A2FA;
         5'd15: v = 34'sh00000517D;
         5'd16: v = 34'sh0000028BE;
         5'd17: v = 34'sh00000145F;
         5'd18: v = 34'sh000000A30;
         5'd19: v = 34'sh000000518;
         5'd20: v = 34'sh00000028C;
         5'd21: v = 34'sh000000146;
         5'd22: v = 34'sh0000000A3;
         5'd23: v = 34'sh000000051;
         5'd24: v = 34'sh000000029;
         5'd25: v = 34'sh000000014;
         5'd26: v = 34'sh00000000A;
         5'd27: v = 34'sh000000005;
         5'd28: v = 34'sh000000003;
         5'd29: v = 34'sh000000001;
         5'd30: v = 34'sh000000001;
         default: v = 34'sh000000000;
      endcase
      return v;
   endfunction

endpackage

### rtl/ddpu_intf.sv
// Channel interfaces of the differential drive pose update unit.
interface ddpu_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;

   modport source (output valid, mode, left_speed, right_speed, new_x, new_y, input ready);
   modport sink   (input valid, mode, left_speed, right_speed, new_x, new_y, output ready);
endinterface

interface ddpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0]        heading_angle;

   modport source (output valid, pos_x, pos_y, heading_angle, input ready);
   modport sink   (input valid, pos_x, pos_y, heading_angle, output ready);
endinterface

interface ddpu_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ddpu_pkg::CSR_IDX_W-1:0] index;
   logic [15:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ddpu_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddpu_cordic #(
   parameter int CORDIC_STEPS = ddpu_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ddpu_pkg::cordic_req_type req,
   output ddpu_pkg::cordic_rsp_type rsp
);
   localparam int CW = $clog2(CORDIC_STEPS);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic               busy_ff, busy_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [31:0]        ang_adj;
   logic               ang_flip;
   logic signed [33:0] x_sh, y_sh, atan_v;

   // Fold left half-plane angles by half a turn
   always_comb begin
      ang_flip = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
      ang_adj  = ang_flip ? req.angle + 32'h8000_0000 : req.angle;
   end

   // One micro-rotation per cycle
   always_comb begin
      x_sh    = x_ff >>> cnt_ff;
      y_sh    = y_ff >>> cnt_ff;
      atan_v  = ddpu_pkg::atan_at(5'(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req.start) begin
         x_in    = ddpu_pkg::GAIN_Q30;
         y_in    = '0;
         z_in    = 34'(signed'(ang_adj));
         flip_in = ang_flip;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_v;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   // Undo the half-turn fold on the way out
   assign rsp.busy    = busy_ff;
   assign rsp.cos_val = flip_ff ? -x_ff : x_ff;
   assign rsp.sin_val = flip_ff ? -y_ff : y_ff;

endmodule

### rtl/ddpu_mul.sv
// Shared registered 32 by 32 unsigned multiplier.
module ddpu_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);
   logic [63:0] prod_ff, prod_in;

   // Multiply; the product is registered and available in the next cycle
   assign prod_in = {32'd0, op_a} * {32'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

### rtl/ddpu_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module ddpu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ddpu_pkg::div_req_type req,
   output ddpu_pkg::div_rsp_type rsp
);
   localparam int NW = ddpu_pkg::DIV_BITS;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] num_ff, num_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic [31:0]   quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [16:0]   trial, diff;
   logic          fits;

   // Shift in the next dividend bit and try to subtract
   always_comb begin
      trial   = {rem_ff, num_ff[NW-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         num_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/differential_drive_pose_update_unit.sv
// Top level of the differential drive pose update unit: sequencer, pose state, registers.
//
// Keeps x, y (signed Q16.16, saturating) and heading (32-bit binary angle, wrapping).
// Turn, zero-heading and set-position modes change the pose on acceptance; these and unused
// modes go straight to the done state, where the result is loaded into the output register.
// In a step transaction the sequencer issues three products on the shared 32x32 multiplier
// and starts the CORDIC and the restoring divider for the heading step; it waits until
// both have finished, two more products then finish x and y, and the heading and output
// register follow.
// One transaction is in flight at a time; the finished pose waits in an output register,
// and the input is ready again the cycle after it is loaded. A stalled result holds the
// input.
module differential_drive_pose_update_unit #(
   parameter int CORDIC_STEPS = ddpu_pkg::CORDIC_STEPS_DEF
) (
   input logic        clock,
   input logic        reset,
   ddpu_req_if.sink   req_chan,
   ddpu_rsp_if.source rsp_chan,
   ddpu_csr_if.sink   csr_chan
);
   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_DIST = 10'b00_0000_0010,
      ST_DIFF = 10'b00_0000_0100,
      ST_RAD  = 10'b00_0000_1000,
      ST_DIV  = 10'b00_0001_0000,
      ST_WAIT = 10'b00_0010_0000,
      ST_MULX = 10'b00_0100_0000,
      ST_MULY = 10'b00_1000_0000,
      ST_UPDY = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]        radius_ff, radius_in, track_ff, track_in;
   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [31:0]        cur_head_ff, cur_head_in;
   logic signed [15:0] ls_ff, ls_in, rs_ff, rs_in;
   logic [31:0]        dist_mag_ff, dist_mag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [31:0]        out_head_ff, out_head_in;

   logic               accept, out_load;
   logic signed [16:0] sum_s, diff_s;
   logic [16:0]        sum_mag, diff_mag;
   logic [15:0]        track_eff;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [31:0]        cos_mag, sin_mag;
   logic               delta_neg;
   logic signed [64:0] prod_s, prod_r;
   logic signed [33:0] delta;
   logic signed [31:0] cur_pos;
   logic signed [34:0] pos_sum;
   logic signed [31:0] pos_sat;
   logic [63:0]        head_num;

   ddpu_pkg::cordic_req_type cordic_req;
   ddpu_pkg::cordic_rsp_type cordic_rsp;
   ddpu_pkg::div_req_type    div_req;
   ddpu_pkg::div_rsp_type    div_rsp;

   ddpu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   ddpu_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   ddpu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Wheel speed sum and difference
   always_comb begin
      sum_s     = 17'(ls_ff) + 17'(rs_ff);
      diff_s    = 17'(ls_ff) - 17'(rs_ff);
      sum_mag   = sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
      diff_mag  = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);
      track_eff = (track_ff == 16'd0) ? 16'd1 : track_ff;
      cos_mag   = cordic_rsp.cos_val[33] ? 32'(-cordic_rsp.cos_val) : 32'(cordic_rsp.cos_val);
      sin_mag   = cordic_rsp.sin_val[33] ? 32'(-cordic_rsp.sin_val) : 32'(cordic_rsp.sin_val);
   end

   // Select multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DIST: begin
            mul_a = {16'd0, radius_ff};
            mul_b = {15'd0, sum_mag};
         end
         ST_DIFF: begin
            mul_a = {16'd0, radius_ff};
            mul_b = {15'd0, diff_mag};
         end
         ST_RAD: begin
            mul_a = mul_p[31:0];
            mul_b = ddpu_pkg::RAD_TO_ANGLE;
         end
         ST_MULX: begin
            mul_a = dist_mag_ff;
            mul_b = cos_mag;
         end
         ST_MULY: begin
            mul_a = dist_mag_ff;
            mul_b = sin_mag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Launch CORDIC and divider
   always_comb begin
      head_num           = mul_p + {41'd0, track_eff, 7'd0};
      cordic_req.start   = (state_ff == ST_DIST);
      cordic_req.angle   = cur_head_ff;
      div_req.start      = (state_ff == ST_DIV);
      div_req.dividend   = head_num[ddpu_pkg::DIV_BITS+7:8];
      div_req.divisor    = track_eff;
   end

   // Position delta: round product to nearest and saturate the sum
   always_comb begin
      delta_neg = sum_s[16] ^ ((state_ff == ST_MULY) ? cordic_rsp.cos_val[33]
                                                     : cordic_rsp.sin_val[33]);
      prod_s    = delta_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
      prod_r    = (prod_s + 65'sh0_4000_0000) >>> 31;
      delta     = prod_r[33:0];
      cur_pos   = (state_ff == ST_MULY) ? cur_x_ff : cur_y_ff;
      pos_sum   = 35'(cur_pos) + 35'(delta);
      if ((pos_sum[34:31] == 4'b0000) || (pos_sum[34:31] == 4'b1111)) begin
         pos_sat = pos_sum[31:0];
      end else if (pos_sum[34]) begin
         pos_sat = 32'sh8000_0000;
      end else begin
         pos_sat = 32'sh7FFF_FFFF;
      end
   end

   // Sequencer and pose state
   always_comb begin
      state_in    = state_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      cur_head_in = cur_head_ff;
      ls_in       = ls_ff;
      rs_in       = rs_ff;
      dist_mag_in = dist_mag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ls_in    = req_chan.left_speed;
               rs_in    = req_chan.right_speed;
               state_in = ST_DONE;
               case (ddpu_pkg::mode_type'(req_chan.mode))
                  ddpu_pkg::MODE_STEP:         state_in = ST_DIST;
                  ddpu_pkg::MODE_TURN_LEFT:
                     cur_head_in = cur_head_ff + ddpu_pkg::HALF_DEG_ANGLE;
                  ddpu_pkg::MODE_TURN_RIGHT:
                     cur_head_in = cur_head_ff - ddpu_pkg::HALF_DEG_ANGLE;
                  ddpu_pkg::MODE_ZERO_HEADING: cur_head_in = '0;
                  ddpu_pkg::MODE_SET_POS: begin
                     cur_x_in = req_chan.new_x;
                     cur_y_in = req_chan.new_y;
                  end
                  default:                     state_in = ST_DONE;
               endcase
            end
         end
         ST_DIST: state_in = ST_DIFF;
         ST_DIFF: begin
            dist_mag_in = mul_p[31:0];
            state_in    = ST_RAD;
         end
         ST_RAD:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (!cordic_rsp.busy && !div_rsp.busy) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: state_in = ST_MULY;
         ST_MULY: begin
            cur_x_in = pos_sat;
            state_in = ST_UPDY;
         end
         ST_UPDY: begin
            cur_y_in    = pos_sat;
            cur_head_in = diff_s[16] ? cur_head_ff - div_rsp.quotient
                                     : cur_head_ff + div_rsp.quotient;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration writes
   always_comb begin
      radius_in = radius_ff;
      track_in  = track_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            ddpu_pkg::REG_WHEEL_RADIUS: radius_in = csr_chan.data;
            ddpu_pkg::REG_WHEEL_TRACK:  track_in  = csr_chan.data;
            default: begin
               radius_in = radius_ff;
               track_in  = track_ff;
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_head_in  = out_head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         out_x_in     = cur_x_ff;
         out_y_in     = cur_y_ff;
         out_head_in  = cur_head_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_head_ff  <= '0;
         radius_ff    <= ddpu_pkg::RADIUS_RESET;
         track_ff     <= ddpu_pkg::TRACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_head_ff  <= cur_head_in;
         radius_ff    <= radius_in;
         track_ff     <= track_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ls_ff       <= ls_in;
      rs_ff       <= rs_in;
      dist_mag_ff <= dist_mag_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pos_x         = out_x_ff;
   assign rsp_chan.pos_y         = out_y_ff;
   assign rsp_chan.heading_angle = out_head_ff;

   // Both iterative units have finished before the position products start
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULX) |-> (!cordic_rsp.busy && !div_rsp.busy))
      else $error("position product issued while CORDIC or divider busy");

   // CORDIC is never restarted in mid-rotation
   a_cordic_start: assert property (@(posedge clock) disable iff (reset)
      cordic_req.start |-> !cordic_rsp.busy)
      else $error("CORDIC restarted while busy");

   // Leaving the done state always presents a result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_chan.valid)
      else $error("transaction finished without a result");

endmodule
